[hw/rtl/ace_pkg.sv]
// ----------------------------------------------------------------------------
// ace_pkg: shared types and constants of the aero coefficient evaluator
// Fixed point format, pipeline stage layout, coefficient store layout and
// the lane type of the pipelined rate divider.
// ----------------------------------------------------------------------------
package ace_pkg;

  // fixed point format and coefficient store
  localparam int FRAC_BITS    = 16;
  localparam int COEF_ENTRIES = 64;
  localparam int STORE_DEPTH  = 64;
  localparam int IDX_W        = $clog2(STORE_DEPTH);

  // rate divider: 32 quotient bits, two per stage
  localparam int DIV_BITS_PER_STAGE = 2;
  localparam int DIV_STAGES         = 32 / DIV_BITS_PER_STAGE;

  // pipeline stage numbers
  localparam int ST_IN      = 0;
  localparam int ST_MUL     = 1;
  localparam int ST_ABS     = 2;
  localparam int ST_DIV0    = 3;
  localparam int ST_CLIP    = ST_DIV0 + DIV_STAGES;
  localparam int ST_PROD    = ST_CLIP + 1;
  localparam int ST_PSUM    = ST_PROD + 1;
  localparam int ST_OUT     = ST_PSUM + 1;
  localparam int NUM_STAGES = ST_OUT + 1;

  // term and sum widths: 32x33 product floored by FRAC_BITS, eleven terms summed
  localparam int TERM_W = 65 - FRAC_BITS;
  localparam int SUM_W  = TERM_W + 4;

  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // coefficient store layout, force group first, moment group three words on (nine words on in RMAT and SMAT)
  localparam int CI_BASE  = 0;
  localparam int CI_ALPHA = 6;
  localparam int CI_ELEV  = 12;
  localparam int CI_BETA  = 18;
  localparam int CI_RMAT  = 24;
  localparam int CI_SMAT  = 42;

  typedef enum logic [1:0] {
    CFG_HALF_SPAN    = 2'd0,
    CFG_HALF_CHORD   = 2'd1,
    CFG_EXTRA_AXIAL  = 2'd2,
    CFG_MIN_AIRSPEED = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    KIND_EVAL = 1'b0,
    KIND_LOAD = 1'b1
  } kind_e;

  // one divider beat: three lanes sharing one divisor
  typedef struct packed {
    logic [30:0]       divisor;
    logic [2:0][30:0]  rem;
    logic [2:0][31:0]  lq;
  } div_lane_t;

endpackage

[hw/rtl/ace_rate_div.sv]
// ----------------------------------------------------------------------------
// ace_rate_div: pipelined restoring divider for the three rate lanes
// Each stage retires two quotient bits per lane. The low dividend word is
// shifted out while quotient bits shift in, so after the last stage lq
// holds the 32-bit quotient magnitude.
// ----------------------------------------------------------------------------
module ace_rate_div import ace_pkg::*; (
  input  logic                  clk_i,
  input  logic [DIV_STAGES-1:0] en_i,
  input  div_lane_t             lane_i,
  output div_lane_t             lane_o
);

  div_lane_t st_q [DIV_STAGES];

  // two restoring steps on every lane
  function automatic div_lane_t div_step(input div_lane_t x);
    div_lane_t  y;
    logic [31:0] r;
    logic        ge;
    y = x;
    for (int c = 0; c < 3; c++) begin
      for (int b = 0; b < DIV_BITS_PER_STAGE; b++) begin
        r  = {y.rem[c], y.lq[c][31]};
        ge = (r >= {1'b0, y.divisor});
        if (ge) begin
          r = r - {1'b0, y.divisor};
        end
        y.lq[c]  = {y.lq[c][30:0], ge};
        y.rem[c] = r[30:0];
      end
    end
    return y;
  endfunction

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    div_lane_t stage_in;

    // stage input mux
    always_comb begin
      if (k == 0) begin
        stage_in = lane_i;
      end else begin
        stage_in = st_q[(k == 0) ? 0 : k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[k]) begin
        st_q[k] <= div_step(stage_in);
      end
    end
  end

  assign lane_o = st_q[DIV_STAGES-1];

endmodule

[hw/rtl/aero_coefficient_evaluator.sv]
// ----------------------------------------------------------------------------
// aero_coefficient_evaluator: linear stability-derivative aero model
// Load beats write one coefficient word; evaluate beats give three force and
// three moment coefficients in Q16.16, saturated, with speed fault and
// saturation flags.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                    | beat
//  in      | input     | in_valid_i / in_stall_o      | kind, coef word, flight state
//  out     | output    | out_valid_o / out_stall_i    | six coefficients, two flags
//  cfg     | input     | cfg_valid_i / cfg_ready_o    | register index and data
//
//  one beat per cycle enters while in_stall_o is low; the rate divider
//  retires two quotient bits per stage
//  coefficients are read in the product stage; a load writes the store when it
//  leaves the stage before it, so loads and evaluates keep their order
//  a stalled output only backs up the pipeline once every stage holds a beat
//  reset clears the valid bits and the configuration registers, but sets the minimum
//  airspeed to 65536; the coefficient store is not reset
// ----------------------------------------------------------------------------
module aero_coefficient_evaluator import ace_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [5:0]  coef_index_i,
  input  logic [31:0] coef_value_i,
  input  logic [30:0] airspeed_i,
  input  logic [31:0] attack_angle_i,
  input  logic [31:0] sideslip_angle_i,
  input  logic [31:0] elevator_deg_i,
  input  logic [31:0] surf_b_deg_i,
  input  logic [31:0] surf_c_deg_i,
  input  logic [31:0] roll_rate_i,
  input  logic [31:0] pitch_rate_i,
  input  logic [31:0] yaw_rate_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] force_x_o,
  output logic [31:0] force_y_o,
  output logic [31:0] force_z_o,
  output logic [31:0] moment_x_o,
  output logic [31:0] moment_y_o,
  output logic [31:0] moment_z_o,
  output logic        speed_fault_o,
  output logic        saturated_o
);

  typedef struct packed {
    kind_e              kind;
    logic [IDX_W-1:0]   idx;
    logic [31:0]        val;
    logic [30:0]        airspeed;
    logic               fault;
    logic signed [32:0] aoa;
    logic signed [32:0] de;
    logic signed [32:0] t;
    logic signed [32:0] at;
    logic signed [32:0] sv0;
    logic signed [32:0] sv1;
  } ctx_t;

  // configuration registers
  logic [30:0]        half_span_q, half_chord_q, min_airspeed_q;
  logic signed [31:0] extra_axial_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_span_q    <= '0;
      half_chord_q   <= '0;
      extra_axial_q  <= '0;
      min_airspeed_q <= 31'd65536;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_HALF_SPAN:    half_span_q    <= cfg_data_i[30:0];
        CFG_HALF_CHORD:   half_chord_q   <= cfg_data_i[30:0];
        CFG_EXTRA_AXIAL:  extra_axial_q  <= cfg_data_i;
        CFG_MIN_AIRSPEED: min_airspeed_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // stage valid bits and ready chain
  logic [NUM_STAGES-1:0] v_q, v_d, rdy;

  always_comb begin
    rdy[NUM_STAGES-1] = !v_q[NUM_STAGES-1] || !out_stall_i;
    for (int k = NUM_STAGES-2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k+1];
    end
  end

  assign in_stall_o = !rdy[ST_IN];

  ctx_t ctx_q [ST_CLIP+1];

  // loads leave the pipeline at the clip stage and never enter the product stage
  always_comb begin
    v_d[ST_IN] = in_valid_i;
    for (int k = 1; k < NUM_STAGES; k++) begin
      v_d[k] = v_q[k-1];
    end
    v_d[ST_PROD] = v_q[ST_CLIP] && (ctx_q[ST_CLIP].kind == KIND_EVAL);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (rdy[k]) v_q[k] <= v_d[k];
      end
    end
  end

  // input stage: sign handling and speed check
  ctx_t        ctx_d;
  logic [2:0][31:0] rate_q;

  always_comb begin
    ctx_d.kind     = kind_e'(kind_i);
    ctx_d.idx      = coef_index_i;
    ctx_d.val      = coef_value_i;
    ctx_d.airspeed = airspeed_i;
    ctx_d.fault    = (airspeed_i == '0) || (airspeed_i < min_airspeed_q);
    ctx_d.aoa      = {attack_angle_i[31], attack_angle_i};
    ctx_d.de       = {elevator_deg_i[31], elevator_deg_i};
    ctx_d.t        = -$signed({sideslip_angle_i[31], sideslip_angle_i});
    ctx_d.at       = ctx_d.t[32] ? -ctx_d.t : ctx_d.t;
    ctx_d.sv0      = -$signed({surf_b_deg_i[31], surf_b_deg_i});
    ctx_d.sv1      = -$signed({surf_c_deg_i[31], surf_c_deg_i});
  end

  always_ff @(posedge clk_i) begin
    if (rdy[ST_IN]) begin
      ctx_q[ST_IN] <= ctx_d;
      rate_q       <= {yaw_rate_i, pitch_rate_i, roll_rate_i};
    end
    for (int k = 1; k <= ST_CLIP; k++) begin
      if (rdy[k]) ctx_q[k] <= ctx_q[k-1];
    end
  end

  // scale times rate
  logic signed [63:0] prod_q [3];
  logic [30:0]        scale [3];

  assign scale[0] = half_span_q;
  assign scale[1] = half_chord_q;
  assign scale[2] = half_span_q;

  always_ff @(posedge clk_i) begin
    if (rdy[ST_MUL]) begin
      for (int c = 0; c < 3; c++) begin
        prod_q[c] <= $signed({1'b0, scale[c]}) * $signed(rate_q[c]);
      end
    end
  end

  // magnitude, overflow check and divider setup
  div_lane_t   div_in_d, div_in_q, div_out;
  logic [2:0]  neg_d, ovf_d;
  logic [2:0]  neg_q [ST_ABS:ST_CLIP-1];
  logic [2:0]  ovf_q [ST_ABS:ST_CLIP-1];
  logic [63:0] mag [3];

  always_comb begin
    div_in_d.divisor = ctx_q[ST_MUL].airspeed;
    for (int c = 0; c < 3; c++) begin
      neg_d[c] = prod_q[c][63];
      mag[c]   = prod_q[c][63] ? 64'(-prod_q[c]) : 64'(prod_q[c]);
      div_in_d.rem[c] = mag[c][62:32];
      div_in_d.lq[c]  = mag[c][31:0];
      ovf_d[c] = (mag[c][62:32] >= ctx_q[ST_MUL].airspeed);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[ST_ABS]) begin
      div_in_q      <= div_in_d;
      neg_q[ST_ABS] <= neg_d;
      ovf_q[ST_ABS] <= ovf_d;
    end
    for (int k = ST_ABS+1; k <= ST_CLIP-1; k++) begin
      if (rdy[k]) begin
        neg_q[k] <= neg_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  ace_rate_div u_rate_div (
    .clk_i  (clk_i),
    .en_i   (rdy[ST_DIV0 +: DIV_STAGES]),
    .lane_i (div_in_q),
    .lane_o (div_out)
  );

  // quotient sign and clip
  logic signed [31:0] rv_d [3];
  logic signed [31:0] rv_q [3];
  logic               rsat_d, rsat_q;

  always_comb begin
    rsat_d = 1'b0;
    for (int c = 0; c < 3; c++) begin
      if (ctx_q[ST_CLIP-1].fault) begin
        rv_d[c] = '0;
      end else if (!neg_q[ST_CLIP-1][c]) begin
        if (ovf_q[ST_CLIP-1][c] || div_out.lq[c][31]) begin
          rv_d[c] = S32_MAX;
          rsat_d  = 1'b1;
        end else begin
          rv_d[c] = $signed(div_out.lq[c]);
        end
      end else begin
        if (ovf_q[ST_CLIP-1][c] || (div_out.lq[c] > 32'h8000_0000)) begin
          rv_d[c] = S32_MIN;
          rsat_d  = 1'b1;
        end else begin
          rv_d[c] = $signed(-div_out.lq[c]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[ST_CLIP]) begin
      rv_q   <= rv_d;
      rsat_q <= rsat_d;
    end
  end

  // coefficient store, written as a load beat leaves the clip stage
  logic [31:0] coef_q [STORE_DEPTH];
  logic        store_we;

  assign store_we = v_q[ST_CLIP] && (ctx_q[ST_CLIP].kind == KIND_LOAD) && rdy[ST_PROD] &&
                    ({1'b0, ctx_q[ST_CLIP].idx} < (IDX_W+1)'(COEF_ENTRIES));

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      coef_q[ctx_q[ST_CLIP].idx] <= ctx_q[ST_CLIP].val;
    end
  end

  // multiplicand set: aoa, de, t, |t|, three rates, two surface terms
  logic signed [32:0] var_w [9];

  always_comb begin
    var_w[0] = ctx_q[ST_CLIP].aoa;
    var_w[1] = ctx_q[ST_CLIP].de;
    var_w[2] = ctx_q[ST_CLIP].t;
    var_w[3] = ctx_q[ST_CLIP].at;
    var_w[4] = 33'(rv_q[0]);
    var_w[5] = 33'(rv_q[1]);
    var_w[6] = 33'(rv_q[2]);
    var_w[7] = ctx_q[ST_CLIP].sv0;
    var_w[8] = ctx_q[ST_CLIP].sv1;
  end

  logic signed [TERM_W-1:0] term_q [6][9];
  logic signed [31:0]       base_q [6];
  logic signed [SUM_W-1:0]  psum_q [6][3];
  logic [31:0]              res_q  [6];
  logic                     fault_p_q, sat_p_q, fault_s_q, sat_s_q, fault_o_q, sat_o_q;

  for (genvar o = 0; o < 6; o++) begin : g_out
    localparam int AX      = o % 3;
    localparam int GRP     = o / 3;
    localparam bit USE_ABS = (GRP == 0) ? (AX != 1) : (AX == 1);

    for (genvar j = 0; j < 9; j++) begin : g_term
      localparam int VI = (j == 0) ? 0 : (j == 1) ? 1 : (j == 2) ? (USE_ABS ? 3 : 2) :
                          (j <= 5) ? (j + 1) : (j == 6) ? 7 : 8;
      localparam int CI = (j == 0) ? (CI_ALPHA + 3*GRP + AX) :
                          (j == 1) ? (CI_ELEV + 3*GRP + AX) :
                          (j == 2) ? (CI_BETA + 3*GRP + AX) :
                          (j <= 5) ? (CI_RMAT + 9*GRP + 3*AX + (j - 3)) :
                                     (CI_SMAT + 9*GRP + 3*AX + (j - 6));
      logic signed [64:0] p;

      // product floored by the fraction width
      assign p = $signed(coef_q[CI]) * var_w[VI];

      always_ff @(posedge clk_i) begin
        if (rdy[ST_PROD]) term_q[o][j] <= p[64:FRAC_BITS];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[ST_PROD]) base_q[o] <= $signed(coef_q[CI_BASE + 3*GRP + AX]);
    end

    // partial sums, axial extra on force x
    logic signed [SUM_W-1:0] extra;
    assign extra = (o == 0) ? SUM_W'(extra_axial_q) : '0;

    always_ff @(posedge clk_i) begin
      if (rdy[ST_PSUM]) begin
        psum_q[o][0] <= SUM_W'(base_q[o]) + SUM_W'(term_q[o][0]) + SUM_W'(term_q[o][1])
                        + SUM_W'(term_q[o][2]) + extra;
        psum_q[o][1] <= SUM_W'(term_q[o][3]) + SUM_W'(term_q[o][4]) + SUM_W'(term_q[o][5]);
        psum_q[o][2] <= SUM_W'(term_q[o][6]) + SUM_W'(term_q[o][7]) + SUM_W'(term_q[o][8]);
      end
    end
  end

  // flags along the sum stages
  always_ff @(posedge clk_i) begin
    if (rdy[ST_PROD]) begin
      fault_p_q <= ctx_q[ST_CLIP].fault;
      sat_p_q   <= rsat_q;
    end
    if (rdy[ST_PSUM]) begin
      fault_s_q <= fault_p_q;
      sat_s_q   <= sat_p_q;
    end
  end

  // final sum and saturation into the output register
  logic signed [SUM_W-1:0] total [6];
  logic [31:0]             res_d [6];
  logic                    clip_any;

  always_comb begin
    clip_any = 1'b0;
    for (int o = 0; o < 6; o++) begin
      total[o] = psum_q[o][0] + psum_q[o][1] + psum_q[o][2];
      if (total[o] > SUM_W'(S32_MAX)) begin
        res_d[o] = S32_MAX;
        clip_any = 1'b1;
      end else if (total[o] < SUM_W'(S32_MIN)) begin
        res_d[o] = S32_MIN;
        clip_any = 1'b1;
      end else begin
        res_d[o] = total[o][31:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[ST_OUT]) begin
      res_q     <= res_d;
      fault_o_q <= fault_s_q;
      sat_o_q   <= sat_s_q || clip_any;
    end
  end

  assign out_valid_o   = v_q[ST_OUT];
  assign force_x_o     = res_q[0];
  assign force_y_o     = res_q[1];
  assign force_z_o     = res_q[2];
  assign moment_x_o    = res_q[3];
  assign moment_y_o    = res_q[4];
  assign moment_z_o    = res_q[5];
  assign speed_fault_o = fault_o_q;
  assign saturated_o   = sat_o_q;

  // empty output stage never backs up the input
  a_no_stall_when_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output stage");

  // input stalls only with every stage occupied
  a_stall_only_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&v_q))
    else $error("input stalled with a bubble in the pipeline");

  // a load beat never reaches the product stage
  a_load_dropped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[ST_CLIP] && (ctx_q[ST_CLIP].kind == KIND_LOAD) && rdy[ST_PROD])
      |=> !v_q[ST_PROD])
    else $error("load beat passed into product stage");

  // zero airspeed always raises the speed fault
  a_zero_speed_fault : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (airspeed_i == '0)) |=> ctx_q[ST_IN].fault)
    else $error("zero airspeed without speed fault");

endmodule
